[rtl/ris_pkg.sv]
`default_nettype none

package ris_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int NAME_BYTES  = 8;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int YEAR_W  = 3;
    localparam int GRADE_W = 7;
    localparam int NAME_W  = 64;
    localparam int KEY_W   = YEAR_W + GRADE_W + NAME_W;

    // only the low NAME_BYTES bytes of the surname take part in the compare
    localparam logic [NAME_W-1:0] NAME_MASK = (64'd1 << (8 * NAME_BYTES)) - 64'd1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } ris_entry_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } ris_ctl_t;

endpackage

`default_nettype wire

[rtl/ris_cell.sv]
`default_nettype none

module ris_cell
    import ris_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ris_ctl_t   ctl,
    input  wire ris_entry_t new_entry,
    input  wire ris_entry_t left_entry,
    input  wire logic       left_gt,
    input  wire ris_entry_t right_entry,
    output logic            gt,
    output ris_entry_t      entry
);

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // empty cells sort after everything, so the free tail stays at the end
    assign gt = !valid_reg || (key_reg > new_entry.key);

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.idx   = idx_reg;

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        if (ctl.insert && gt) begin
            if (left_gt) begin
                valid_next = left_entry.valid;
                key_next   = left_entry.key;
                idx_next   = left_entry.idx;
            end else begin
                valid_next = new_entry.valid;
                key_next   = new_entry.key;
                idx_next   = new_entry.idx;
            end
        end else if (ctl.shift_out) begin
            valid_next = right_entry.valid;
            key_next   = right_entry.key;
            idx_next   = right_entry.idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
        idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

[rtl/record_index_insertion_sort.sv]
// record_index_insertion_sort: stable index sort of student records
//
// input stream (s_): one record per word, s_tlast marks the final record of a
// batch. records sort by year, then grade, then surname; equal keys keep their
// arrival order. up to MAX_RECORDS records are held, later ones in a batch are
// dropped, but their tlast still closes the batch.
// output stream (m_): one word per held record carrying its arrival index in
// ascending key order, m_tlast on the final index.
// each record is placed by a row of cells in the cycle it is accepted, so
// records are taken at one per cycle while no batch drains. the first index is
// offered the cycle after the tlast record is accepted; held records drain at one
// index per cycle when the receiver is always ready, shifted out of cell 0.
// s_tready is low while a batch drains; a receiver stall simply holds the
// row, and the next batch is taken once the final index has been delivered.
// reset (aresetn low, synchronous) empties every cell and clears the count.
`default_nettype none

module record_index_insertion_sort
    import ris_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: study_year[2:0], math_grade[9:3], surname_key[73:10], zero[79:74]
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tlast,   // last_record
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: record_index[5:0], zero[7:6]
    output logic [7:0]       m_tdata,
    output logic             m_tlast,   // final_index
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    logic             draining_reg, draining_next;
    logic [CNT_W-1:0] record_count_reg, record_count_next;

    logic             s_fire;
    logic             m_fire;
    ris_ctl_t         ctl;
    ris_entry_t       new_entry;
    ris_entry_t       empty_entry;
    ris_entry_t       chain [MAX_RECORDS];
    logic             gt    [MAX_RECORDS];

    // unpack the record; surname bytes beyond the compared width are masked
    logic [YEAR_W-1:0]  in_year;
    logic [GRADE_W-1:0] in_grade;
    logic [NAME_W-1:0]  in_name;

    assign in_year  = s_tdata[YEAR_W-1:0];
    assign in_grade = s_tdata[YEAR_W+GRADE_W-1:YEAR_W];
    assign in_name  = s_tdata[KEY_W-1:YEAR_W+GRADE_W] & NAME_MASK;

    assign s_tready = !draining_reg;
    assign s_fire   = s_tvalid && s_tready;

    // key packed year-grade-surname so one unsigned compare gives the order
    assign new_entry.valid = 1'b1;
    assign new_entry.key   = {in_year, in_grade, in_name};
    assign new_entry.idx   = record_count_reg[IDX_W-1:0];

    assign empty_entry.valid = 1'b0;
    assign empty_entry.key   = '0;
    assign empty_entry.idx   = '0;

    assign m_tvalid = draining_reg;
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = {{(8 - IDX_W){1'b0}}, chain[0].idx};
    // final index when the next cell holds nothing
    assign m_tlast  = !chain[1].valid;

    assign ctl.insert    = s_fire && (record_count_reg < CNT_W'(MAX_RECORDS));
    assign ctl.shift_out = m_fire;

    // row of cells: sorted ascending from cell 0, empty cells at the tail
    for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
        ris_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  ((i == 0) ? empty_entry : chain[(i == 0) ? 0 : i - 1]),
            .left_gt     ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
            .right_entry ((i == MAX_RECORDS - 1) ? empty_entry
                          : chain[(i == MAX_RECORDS - 1) ? i : i + 1]),
            .gt          (gt[i]),
            .entry       (chain[i])
        );
    end

    always_comb begin
        draining_next     = draining_reg;
        record_count_next = record_count_reg;
        if (ctl.insert) begin
            record_count_next = record_count_reg + CNT_W'(1);
        end
        if (s_fire && s_tlast) begin
            // batch closed: start draining, next batch numbers from zero
            draining_next     = 1'b1;
            record_count_next = '0;
        end
        if (m_fire && m_tlast) begin
            draining_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draining_reg     <= 1'b0;
            record_count_reg <= '0;
        end else begin
            draining_reg     <= draining_next;
            record_count_reg <= record_count_next;
        end
    end

    // an index is only offered from an occupied head cell
    a_head_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        draining_reg |-> chain[0].valid)
        else $error("draining with empty head cell");

    // the tlast record always opens a drain
    a_last_drains : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> draining_reg)
        else $error("tlast record did not start draining");

    // final index ends the drain and the row is empty afterwards
    a_drain_ends : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_tlast) |=> (!draining_reg && !chain[0].valid))
        else $error("row not empty after final index");

    // count never passes capacity
    a_count_cap : assert property (@(posedge aclk) disable iff (!aresetn)
        record_count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond capacity");

endmodule

`default_nettype wire

[tb/sv/sorted_index_checker.sv]
module sorted_index_checker
    import ris_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: study_year[2:0], math_grade[9:3], surname_key[73:10], zero[79:74]
    input  logic [79:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // m_tdata: record_index[5:0], zero[7:6]
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    output int          mismatch_count,
    output int          indices_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             final_flag;
    } sorted_word_t;

    // sort key: year, grade, masked surname, most significant first
    logic [KEY_W-1:0] held_key [MAX_RECORDS];
    logic [IDX_W-1:0] rank_order [MAX_RECORDS];
    int               held_count = 0;
    sorted_word_t     sorted_q [$];

    task automatic take_record(input logic [79:0] word, input logic closes_batch);
        logic [KEY_W-1:0] key;
        int               pos;
        sorted_word_t     w;
        key = {word[2:0], word[9:3], word[73:10] & NAME_MASK};
        // records past capacity are dropped, but their tlast still closes the batch
        if (held_count < MAX_RECORDS) begin
            pos = held_count;
            held_key[held_count] = key;
            // strict compare keeps equal keys in arrival order
            while (pos > 0 && held_key[rank_order[pos-1]] > key) begin
                rank_order[pos] = rank_order[pos-1];
                pos--;
            end
            rank_order[pos] = IDX_W'(held_count);
            held_count++;
        end
        if (closes_batch) begin
            for (int k = 0; k < held_count; k++) begin
                w.index      = rank_order[k];
                w.final_flag = (k == held_count - 1);
                sorted_q.push_back(w);
            end
            held_count = 0;
        end
    endtask

    task automatic check_index(input logic [7:0] word, input logic flag);
        sorted_word_t want;
        if (sorted_q.size() == 0) begin
            $display("%0t: index word with none expected, expected nothing, got index %0d last %b",
                     $time, word[5:0], flag);
            mismatch_count++;
        end else begin
            want = sorted_q.pop_front();
            if (word[5:0] !== want.index) begin
                $display("%0t: record_index mismatch, expected %0d, got %0d",
                         $time, want.index, word[5:0]);
                mismatch_count++;
            end
            if (flag !== want.final_flag) begin
                $display("%0t: final_index mismatch, expected %b, got %b",
                         $time, want.final_flag, flag);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count     = 0;
            mismatch_count = 0;
            sorted_q.delete();
        end else begin
            // an index word can never stem from a record taken at this same edge
            if (m_tvalid && m_tready)
                check_index(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                take_record(s_tdata, s_tlast);
        end
        indices_pending = sorted_q.size();
    end

endmodule

[tb/sv/tb_record_index_insertion_sort.sv]
module tb_record_index_insertion_sort;
    timeunit 1ns;
    timeprecision 1ps;

    import ris_pkg::*;

    // receiver hold-off length for the back-pressure phase
    localparam int HOLD_LEN = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [79:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    int fail_count;
    int pending;

    // idle odds in percent, changed per phase
    int tx_idle_pct = 30;
    int rx_idle_pct = 60;

    // long receiver stall, counted in the receiver process only
    bit stall_armed = 1'b0;
    int hold_cycles = 0;

    // small surname pool so that equal keys show up often
    logic [NAME_W-1:0] tie_names [4];

    always #6 aclk = ~aclk;

    record_index_insertion_sort DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    sorted_index_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .mismatch_count  (fail_count),
        .indices_pending (pending)
    );

    // receiver: random ready at the falling edge, or a long hold-off once armed
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_armed && hold_cycles < HOLD_LEN) begin
            m_tready <= 1'b0;
            hold_cycles++;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // surname text packed first byte most significant, zero padded
    function automatic logic [NAME_W-1:0] pack_name(input string s);
        logic [NAME_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            v[63-8*i -: 8] = s[i];
        return v;
    endfunction

    // one record word; valid stays up across back-to-back words
    task automatic send_record(input logic [YEAR_W-1:0] year, input logic [GRADE_W-1:0] grade,
                               input logic [NAME_W-1:0] name, input logic closes);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {6'b0, name, grade, year};
        s_tlast  <= closes;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_random(input logic closes);
        logic [YEAR_W-1:0]  year;
        logic [GRADE_W-1:0] grade;
        logic [NAME_W-1:0]  name;
        int                 mode;
        int                 len;
        mode = $urandom_range(2);
        if (mode == 0) begin
            // crowded keys: few years, grades and names, lots of ties
            year  = YEAR_W'($urandom_range(2, 1));
            grade = GRADE_W'($urandom_range(51, 50));
            name  = tie_names[$urandom_range(3)];
        end else begin
            // out-of-range year and grade now and then, compared as raw bits
            if ($urandom_range(99) < 8)
                year = $urandom_range(1) ? 3'd7 : 3'd0;
            else
                year = YEAR_W'($urandom_range(6, 1));
            if ($urandom_range(99) < 12)
                grade = GRADE_W'($urandom_range(127, 101));
            else
                grade = GRADE_W'($urandom_range(100));
            if (mode == 1) begin
                name = {$urandom, $urandom};
            end else begin
                name = '0;
                len  = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                    name[63-8*i -: 8] = 8'($urandom_range(90, 65));
            end
        end
        send_record(year, grade, name, closes);
    endtask

    task automatic send_batch(input int n);
        for (int i = 0; i < n; i++)
            send_random(i == n - 1);
    endtask

    // one big batch first, then mostly short batches
    task automatic run_phase(input int budget, input int big);
        int sent;
        int n;
        int r;
        send_batch(big);
        sent = big;
        while (sent < budget) begin
            r = $urandom_range(99);
            if (r < 60)
                n = $urandom_range(6, 1);
            else if (r < 90)
                n = $urandom_range(24, 7);
            else
                n = $urandom_range(63, 25);
            send_batch(n);
            sent += n;
        end
    endtask

    initial begin
        for (int i = 0; i < 4; i++)
            tie_names[i] = pack_name($sformatf("SMITH%0d", i % 2));
        tie_names[2] = pack_name("SMITHS");
        tie_names[3] = {$urandom, $urandom};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single-record batches at the field extremes
        send_record(3'd7, 7'd127, '1, 1'b1);
        send_record(3'd0, 7'd0, '0, 1'b1);

        // identical keys keep arrival order
        for (int i = 0; i < 5; i++)
            send_record(3'd3, 7'd77, pack_name("ANNA"), i == 4);

        // surname alone decides, arriving in descending order; prefix sorts first
        send_record(3'd2, 7'd40, pack_name("ZED"), 1'b0);
        send_record(3'd2, 7'd40, pack_name("MAX"), 1'b0);
        send_record(3'd2, 7'd40, pack_name("ALB"), 1'b0);
        send_record(3'd2, 7'd40, pack_name("AL"), 1'b1);

        // year outranks grade, grade outranks surname
        send_record(3'd6, 7'd0, pack_name("BOB"), 1'b0);
        send_record(3'd1, 7'd100, pack_name("AAA"), 1'b0);
        send_record(3'd1, 7'd99, pack_name("ZZZ"), 1'b0);
        send_record(3'd6, 7'd0, pack_name("ADA"), 1'b1);

        // sender idles lightly, receiver heavily; full batch of capacity
        run_phase(140, MAX_RECORDS);

        // roles swapped; overfull batch, the extra records are dropped
        tx_idle_pct = 60;
        rx_idle_pct = 30;
        run_phase(140, MAX_RECORDS + 3);

        // no idling, but the receiver starts with a long hold-off so input backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_armed = 1'b1;
        run_phase(130, 20);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending != 0)
            @(negedge aclk);
        repeat (40) @(negedge aclk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/ris_pkg.sv
rtl/ris_cell.sv
rtl/record_index_insertion_sort.sv
tb/sv/sorted_index_checker.sv
tb/sv/tb_record_index_insertion_sort.sv
